// ===== hw/rtl/ubc_pkg.sv =====
// Shared types, constants and character tables of the ULID Base32 codec.
`default_nettype none
package ubc_pkg;

    localparam int BODY_CHARS   = 26;
    localparam int BINARY_BYTES = 16;
    localparam int PREFIX_LEN   = 4;
    localparam int TEXT_LEN     = PREFIX_LEN + BODY_CHARS;
    localparam int VALUE_W      = 8 * BINARY_BYTES;
    // The text form carries 130 bits; the top two are always zero.
    localparam int EXT_W        = 5 * BODY_CHARS;
    localparam int CNT_W        = 5;
    localparam int MAX_FIRST    = 7;

    // Digits of the Crockford alphabet, digit 0 in the top byte.
    localparam logic [8*32-1:0] ALPHABET = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
    localparam logic [8*PREFIX_LEN-1:0] PREFIX_TEXT = "cnt_";

    typedef enum logic [1:0] {
        JOB_INVALID = 2'd0,
        JOB_BYTES   = 2'd1,
        JOB_TEXT    = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t           kind;
        logic [VALUE_W-1:0]  value;
    } job_t;

    function automatic logic [7:0] prefix_char(input logic [1:0] idx);
        prefix_char = PREFIX_TEXT[8*(PREFIX_LEN-1-int'(idx)) +: 8];
    endfunction

    function automatic logic [7:0] digit_char(input logic [4:0] v);
        digit_char = ALPHABET[8*(31-int'(v)) +: 8];
    endfunction

    // Returns {valid, digit}; lowercase letters are folded to uppercase.
    function automatic logic [5:0] digit_of(input logic [7:0] ch);
        logic [7:0] up;
        logic [5:0] r;
        up = ch;
        if (ch >= 8'h61 && ch <= 8'h7A) begin
            up = ch - 8'd32;
        end
        r = 6'd0;
        if (up >= 8'h30 && up <= 8'h39) begin
            r = {1'b1, 5'(up - 8'h30)};
        end else begin
            case (up)
                8'h41: r = {1'b1, 5'd10};   // A
                8'h42: r = {1'b1, 5'd11};
                8'h43: r = {1'b1, 5'd12};
                8'h44: r = {1'b1, 5'd13};
                8'h45: r = {1'b1, 5'd14};
                8'h46: r = {1'b1, 5'd15};
                8'h47: r = {1'b1, 5'd16};
                8'h48: r = {1'b1, 5'd17};   // H
                8'h4A: r = {1'b1, 5'd18};   // J
                8'h4B: r = {1'b1, 5'd19};
                8'h4D: r = {1'b1, 5'd20};   // M
                8'h4E: r = {1'b1, 5'd21};
                8'h50: r = {1'b1, 5'd22};   // P
                8'h51: r = {1'b1, 5'd23};
                8'h52: r = {1'b1, 5'd24};
                8'h53: r = {1'b1, 5'd25};
                8'h54: r = {1'b1, 5'd26};   // T
                8'h56: r = {1'b1, 5'd27};   // V
                8'h57: r = {1'b1, 5'd28};
                8'h58: r = {1'b1, 5'd29};
                8'h59: r = {1'b1, 5'd30};
                8'h5A: r = {1'b1, 5'd31};   // Z
                default: r = 6'd0;
            endcase
        end
        digit_of = r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ulid_base32_codec.sv =====
// Top level of the ULID Base32 codec: input checker, job queue and output expander.
// Path: the first result of an identifier passes through the queue entry, the back's state
// and shift register, and the output register after its last item is accepted.
// Throughput: one input item per cycle while the queue has room; results leave one per cycle
// while the receiver is ready, after the back picks up the job (30 characters per unpack).
// Reset: synchronous, active-low aresetn clears counters, queue and output valid.
`default_nettype none
module ulid_base32_codec (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Input items.
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic [0:0] s_tuser,   // [0] action: 0 = pack text, 1 = unpack bytes
    input  wire logic       s_tlast,
    // Result items.
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [0:0]      m_tuser,   // [0] status: 1 = invalid identifier
    output logic            m_tlast
);

    // The front checks every item as it arrives: prefix characters against the
    // fixed text, body characters against the Crockford alphabet (case folded),
    // the first body digit against its limit, and the item count and action of
    // the whole identifier. On the item flagged last it hands a single job, the
    // verdict plus the 128-bit value, to the queue and starts over at once.
    logic          fq_valid;
    logic          fq_ready;
    ubc_pkg::job_t fq_job;

    // The queue decouples the two sides, so the next identifier streams in
    // while the output side is still sending out the previous one.
    logic          qb_valid;
    logic          qb_ready;
    ubc_pkg::job_t qb_job;

    ubc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser[0]),
        .s_tlast   (s_tlast),
        .job_valid (fq_valid),
        .job       (fq_job),
        .job_ready (fq_ready)
    );

    ubc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    // The back walks a shift register over the value: eight bits per byte in
    // pack mode, five bits per character in unpack mode after the prefix, and
    // a single item with status set for an invalid identifier.
    ubc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (qb_valid),
        .pop_ready (qb_ready),
        .pop_job   (qb_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser[0]),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/ubc_front.sv =====
// Input side: checks each item and accumulates the value, queues a job per identifier.
`default_nettype none
module ubc_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          s_tuser,
    input  wire logic          s_tlast,
    output logic               job_valid,
    output ubc_pkg::job_t      job,
    input  wire logic          job_ready
);

    logic [ubc_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        err_reg, err_next;
    logic                        mode_reg, mode_next;
    logic [ubc_pkg::VALUE_W-1:0] acc_reg, acc_next;
    logic [5:0]                  dig;
    logic                        ok;
    logic                        accept;

    assign s_tready = job_ready;
    assign accept   = s_tvalid && s_tready;
    assign job_valid = accept && s_tlast;

    always_comb begin
        dig       = ubc_pkg::digit_of(s_tdata);
        mode_next = (cnt_reg == '0) ? s_tuser : mode_reg;
        err_next  = err_reg || ((cnt_reg != '0) && (s_tuser != mode_reg));
        acc_next  = acc_reg;
        if (!mode_next) begin
            if (cnt_reg >= ubc_pkg::CNT_W'(ubc_pkg::TEXT_LEN)) begin
                err_next = 1'b1;
            end else if (cnt_reg < ubc_pkg::CNT_W'(ubc_pkg::PREFIX_LEN)) begin
                if (s_tdata != ubc_pkg::prefix_char(cnt_reg[1:0])) begin
                    err_next = 1'b1;
                end
            end else if (!dig[5] || (cnt_reg == ubc_pkg::CNT_W'(ubc_pkg::PREFIX_LEN)
                                     && dig[4:0] > 5'(ubc_pkg::MAX_FIRST))) begin
                err_next = 1'b1;
            end else begin
                acc_next = {acc_reg[ubc_pkg::VALUE_W-6:0], dig[4:0]};
            end
        end else begin
            if (cnt_reg >= ubc_pkg::CNT_W'(ubc_pkg::BINARY_BYTES)) begin
                err_next = 1'b1;
            end else begin
                acc_next = {acc_reg[ubc_pkg::VALUE_W-9:0], s_tdata};
            end
        end
        // Count saturates at its all-ones value.
        cnt_next = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;

        if (mode_next) begin
            ok = !err_next && (cnt_next == ubc_pkg::CNT_W'(ubc_pkg::BINARY_BYTES));
        end else begin
            ok = !err_next && (cnt_next == ubc_pkg::CNT_W'(ubc_pkg::TEXT_LEN));
        end
        job.value = acc_next;
        if (!ok) begin
            job.kind = ubc_pkg::JOB_INVALID;
        end else if (mode_next) begin
            job.kind = ubc_pkg::JOB_TEXT;
        end else begin
            job.kind = ubc_pkg::JOB_BYTES;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            err_reg  <= 1'b0;
            mode_reg <= 1'b0;
        end else if (accept) begin
            if (s_tlast) begin
                cnt_reg  <= '0;
                err_reg  <= 1'b0;
                mode_reg <= 1'b0;
            end else begin
                cnt_reg  <= cnt_next;
                err_reg  <= err_next;
                mode_reg <= mode_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            acc_reg <= acc_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ubc_queue.sv =====
// Two-entry job queue between the input side and the output side.
`default_nettype none
module ubc_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire ubc_pkg::job_t push_job,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output ubc_pkg::job_t      pop_job
);

    ubc_pkg::job_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ubc_back.sv =====
// Output side: expands one queued job into bytes, characters or an invalid item.
`default_nettype none
module ubc_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  wire ubc_pkg::job_t pop_job,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BYTES = 4'b0010,
        ST_TEXT  = 4'b0100,
        ST_ERR   = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [ubc_pkg::EXT_W-1:0]   shift_reg, shift_next;
    logic [ubc_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_byte_reg;
    logic                        out_status_reg;
    logic                        out_last_reg;
    logic                        out_free;
    logic                        emit;
    logic [7:0]                  emit_byte;
    logic                        emit_status;
    logic                        emit_last;

    assign pop_ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_byte_reg;
    assign m_tuser   = out_status_reg;
    assign m_tlast   = out_last_reg;

    always_comb begin
        state_next  = state_reg;
        shift_next  = shift_reg;
        idx_next    = idx_reg;
        emit        = 1'b0;
        emit_byte   = 8'd0;
        emit_status = 1'b0;
        emit_last   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    shift_next = {2'b00, pop_job.value};
                    idx_next   = '0;
                    case (pop_job.kind)
                        ubc_pkg::JOB_BYTES: state_next = ST_BYTES;
                        ubc_pkg::JOB_TEXT:  state_next = ST_TEXT;
                        default:            state_next = ST_ERR;
                    endcase
                end
            end
            ST_BYTES: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_byte  = shift_reg[ubc_pkg::VALUE_W-1 -: 8];
                    emit_last  = (idx_reg == ubc_pkg::CNT_W'(ubc_pkg::BINARY_BYTES - 1));
                    shift_next = shift_reg << 8;
                    idx_next   = idx_reg + 1'b1;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TEXT: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (idx_reg < ubc_pkg::CNT_W'(ubc_pkg::PREFIX_LEN)) begin
                        emit_byte = ubc_pkg::prefix_char(idx_reg[1:0]);
                    end else begin
                        emit_byte  = ubc_pkg::digit_char(shift_reg[ubc_pkg::EXT_W-1 -: 5]);
                        shift_next = shift_reg << 5;
                    end
                    emit_last = (idx_reg == ubc_pkg::CNT_W'(ubc_pkg::TEXT_LEN - 1));
                    idx_next  = idx_reg + 1'b1;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_status = 1'b1;
                    emit_last   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        idx_reg   <= idx_next;
        if (emit) begin
            out_byte_reg   <= emit_byte;
            out_status_reg <= emit_status;
            out_last_reg   <= emit_last;
        end
    end

endmodule
`default_nettype wire

// ===== test/tb_ulid_base32_codec.sv =====
// Self-checking testbench for the ULID Base32 codec, with a scoreboard that predicts each result.

localparam bit ACT_PACK   = 1'b0;   // text character to be packed
localparam bit ACT_UNPACK = 1'b1;   // binary byte to be unpacked
localparam bit ST_OK      = 1'b0;
localparam bit ST_INVALID = 1'b1;

localparam int PREFIX_CHARS   = 4;
localparam int TEXT_CHARS     = 30;
localparam int ID_BYTES       = 16;
localparam int BODY_DIGITS    = 26;
localparam int MAX_LEAD_DIGIT = 7;

localparam bit [8*32-1:0] CROCK_DIGITS = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
localparam bit [8*4-1:0]  ID_PREFIX    = "cnt_";
localparam bit [8*8-1:0]  BAD_LETTERS  = "ILOUilou";

typedef struct packed {
    bit       act;
    bit [7:0] data;
    bit       tail;
} stim_item_t;

typedef struct packed {
    bit [7:0] data;
    bit       status;
    bit       tail;
} id_result_t;

function automatic bit [7:0] crock_char(bit [4:0] v);
    return CROCK_DIGITS[8*(31-int'(v)) +: 8];
endfunction

function automatic bit [7:0] prefix_char_at(int p);
    return ID_PREFIX[8*(PREFIX_CHARS-1-p) +: 8];
endfunction

// Digit value of a character, or -1 when it is not in the alphabet.
function automatic int crock_value(bit [7:0] ch);
    bit [7:0] up;
    up = ch;
    if (ch >= 8'h61 && ch <= 8'h7A) begin
        up = ch - 8'd32;
    end
    for (int i = 0; i < 32; i++) begin
        if (crock_char(5'(i)) == up) begin
            return i;
        end
    end
    return -1;
endfunction

class id_scoreboard;
    bit [127:0] acc;
    bit [4:0]   count;
    bit         broken;
    bit         mode;
    id_result_t expected_q[$];
    int         errors;
    int         checked;
    int         ok_ids;
    int         invalid_ids;

    function new();
        errors      = 0;
        checked     = 0;
        ok_ids      = 0;
        invalid_ids = 0;
        restart();
    endfunction

    function void restart();
        acc    = '0;
        count  = '0;
        broken = 1'b0;
        mode   = ACT_PACK;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void push_result(bit [7:0] d, bit st, bit lst);
        id_result_t r;
        r.data   = d;
        r.status = st;
        r.tail   = lst;
        expected_q.push_back(r);
    endfunction

    // Updates the running identifier with one accepted item and queues its results.
    function void note_item(bit act, bit [7:0] d, bit lst);
        int         pos;
        int         v;
        bit [129:0] wide;
        pos = count;
        if (pos == 0) begin
            mode = act;
        end else if (act != mode) begin
            broken = 1'b1;
        end
        if (mode == ACT_PACK) begin
            if (pos >= TEXT_CHARS) begin
                broken = 1'b1;
            end else if (pos < PREFIX_CHARS) begin
                if (d != prefix_char_at(pos)) begin
                    broken = 1'b1;
                end
            end else begin
                v = crock_value(d);
                if (v < 0 || (pos == PREFIX_CHARS && v > MAX_LEAD_DIGIT)) begin
                    broken = 1'b1;
                end else begin
                    acc = {acc[122:0], v[4:0]};
                end
            end
        end else begin
            if (pos >= ID_BYTES) begin
                broken = 1'b1;
            end else begin
                acc = {acc[119:0], d};
            end
        end
        if (count != 5'd31) begin
            count++;
        end
        if (!lst) begin
            return;
        end
        if (broken || count != ((mode == ACT_PACK) ? TEXT_CHARS : ID_BYTES)) begin
            push_result(8'h00, ST_INVALID, 1'b1);
            invalid_ids++;
        end else if (mode == ACT_PACK) begin
            for (int i = 0; i < ID_BYTES; i++) begin
                push_result(acc[127-8*i -: 8], ST_OK, i == ID_BYTES - 1);
            end
            ok_ids++;
        end else begin
            for (int i = 0; i < PREFIX_CHARS; i++) begin
                push_result(prefix_char_at(i), ST_OK, 1'b0);
            end
            // The text form is 130 bits wide; the lead digit holds the top three.
            wide = {2'b00, acc};
            for (int i = 0; i < BODY_DIGITS; i++) begin
                push_result(crock_char(wide[125-5*i +: 5]), ST_OK, i == BODY_DIGITS - 1);
            end
            ok_ids++;
        end
        restart();
    endfunction

    function void check_result(bit [7:0] d, bit st, bit lst);
        id_result_t want;
        checked++;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("unexpected result: data %02h status %0d last %0d", d, st, lst);
            end
            return;
        end
        want = expected_q.pop_front();
        if (want.data != d || want.status != st || want.tail != lst) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch at result %0d: expected data %02h status %0d last %0d,",
                         checked, want.data, want.status, want.tail);
                $display("    got data %02h status %0d last %0d", d, st, lst);
            end
        end
    endfunction
endclass

module tb_ulid_base32_codec;

    // Long output hold used to back the block up, watchdog limit and drain tail.
    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 16;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [0:0] s_tuser;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;
    logic       m_tlast;

    id_scoreboard sb;
    stim_item_t   stim_q[$];
    int           tx_idle_pct  = 0;
    int           rx_stall_pct = 0;
    int           rx_hold      = 0;
    int           items_sent   = 0;
    int           ids_sent     = 0;
    int           quiet_cycles = 0;

    ulid_base32_codec dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // The receiver either honors a long hold requested by the stimulus or stalls at random.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // Every result taken by the receiver goes straight to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser[0], m_tlast);
        end
    end

    // The watchdog ends a run in which neither side has moved an item for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, sb.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void add_item(bit act, bit [7:0] d);
        stim_item_t it;
        it.act  = act;
        it.data = d;
        it.tail = 1'b0;
        stim_q.push_back(it);
    endfunction

    function automatic void close_id();
        stim_q[stim_q.size()-1].tail = 1'b1;
    endfunction

    // Well-formed text for a value; letters are lowercased with the given chance.
    function automatic void add_text(bit [127:0] value, int lc_pct);
        bit [129:0] wide;
        bit [7:0]   ch;
        for (int p = 0; p < PREFIX_CHARS; p++) begin
            add_item(ACT_PACK, prefix_char_at(p));
        end
        wide = {2'b00, value};
        for (int i = 0; i < BODY_DIGITS; i++) begin
            ch = crock_char(wide[125-5*i +: 5]);
            if (ch >= 8'h41 && $urandom_range(0, 99) < lc_pct) begin
                ch = ch + 8'd32;
            end
            add_item(ACT_PACK, ch);
        end
    endfunction

    function automatic void add_bytes(bit [127:0] value);
        for (int i = 0; i < ID_BYTES; i++) begin
            add_item(ACT_UNPACK, value[127-8*i -: 8]);
        end
    endfunction

    function automatic void add_either(bit [127:0] value);
        if ($urandom_range(0, 1) == 1) begin
            add_text(value, 50);
        end else begin
            add_bytes(value);
        end
    endfunction

    function automatic bit [127:0] random_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom, $urandom, $urandom};
        endcase
    endfunction

    // One identifier: mostly well-formed with random content, the rest broken or noise.
    function automatic void build_random_id();
        int kind;
        int idx;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            add_text(random_value(), $urandom_range(0, 100));
        end else if (kind < 65) begin
            add_bytes(random_value());
        end else begin
            case ($urandom_range(0, 6))
                0: begin
                    // A body character outside the alphabet.
                    add_text(random_value(), 30);
                    idx = $urandom_range(PREFIX_CHARS, TEXT_CHARS - 1);
                    if ($urandom_range(0, 1) == 1) begin
                        stim_q[idx].data = BAD_LETTERS[8*$urandom_range(0, 7) +: 8];
                    end else begin
                        stim_q[idx].data = 8'($urandom_range(0, 255));
                    end
                end
                1: begin
                    // A valid digit that is too large to lead the body.
                    add_text(random_value(), 30);
                    stim_q[PREFIX_CHARS].data = crock_char(5'($urandom_range(8, 31)));
                end
                2: begin
                    // One flipped bit in the prefix, which catches case changes too.
                    add_text(random_value(), 30);
                    idx = $urandom_range(0, PREFIX_CHARS - 1);
                    stim_q[idx].data = stim_q[idx].data ^ (8'd1 << $urandom_range(0, 7));
                end
                3: begin
                    add_either(random_value());
                    n = $urandom_range(1, stim_q.size() - 1);
                    repeat (n) void'(stim_q.pop_back());
                end
                4: begin
                    // Overlong; some runs go past the point where the item count saturates.
                    add_either(random_value());
                    n = ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(1, 4);
                    repeat (n) add_item(stim_q[0].act, 8'($urandom_range(0, 255)));
                end
                5: begin
                    add_either(random_value());
                    idx = $urandom_range(0, stim_q.size() - 1);
                    stim_q[idx].act = ~stim_q[idx].act;
                end
                default: begin
                    n = $urandom_range(1, 6);
                    repeat (n) add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
            endcase
        end
        close_id();
    endfunction

    task automatic send_item(stim_item_t it);
        s_tvalid <= 1'b1;
        s_tdata  <= it.data;
        s_tuser  <= it.act;
        s_tlast  <= it.tail;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(it.act, it.data, it.tail);
        items_sent++;
    endtask

    task automatic idle_gap();
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Sends the identifier in the queue. Valid stays high across items so that
    // back-to-back identifiers leave no gap when the sender does not idle.
    task automatic send_queue();
        for (int i = 0; i < stim_q.size(); i++) begin
            idle_gap();
            send_item(stim_q[i]);
        end
        ids_sent++;
        stim_q.delete();
    endtask

    // The sender pauses until every expected result has come, plus a short tail
    // so that any stray result still in the block shows up as unexpected.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic run_random(int target);
        int start;
        start = items_sent;
        while (items_sent - start < target) begin
            build_random_id();
            send_queue();
        end
    endtask

    task automatic run_directed();
        // All-ones value: a lead digit of 7 and Z everywhere after it.
        add_bytes('1);
        close_id();
        send_queue();
        // Wrong third prefix character, cut short.
        add_item(ACT_PACK, "c");
        add_item(ACT_PACK, "n");
        add_item(ACT_PACK, "X");
        close_id();
        send_queue();
        // Text followed by a binary byte in the same identifier.
        add_item(ACT_PACK, "c");
        add_item(ACT_UNPACK, 8'hAA);
        close_id();
        send_queue();
        // A lone binary byte that is also the last one.
        add_item(ACT_UNPACK, 8'h00);
        close_id();
        send_queue();
        // Lead digit above 7.
        for (int p = 0; p < PREFIX_CHARS; p++) add_item(ACT_PACK, prefix_char_at(p));
        add_item(ACT_PACK, "8");
        close_id();
        send_queue();
        // Excluded letter given in lowercase.
        for (int p = 0; p < PREFIX_CHARS; p++) add_item(ACT_PACK, prefix_char_at(p));
        add_item(ACT_PACK, "i");
        close_id();
        send_queue();
        // All-zero value as text and all-ones value as mixed-case text.
        add_text('0, 0);
        close_id();
        send_queue();
        add_text({3'b111, {125{1'b1}}}, 50);
        close_id();
        send_queue();
    endtask

    initial begin
        sb = new();
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= ACT_PACK;
        s_tlast  <= 1'b0;
        aresetn  <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Neither side idles: directed identifiers first.
        run_directed();
        wait_drained();

        // The receiver holds off for a long stretch while binary identifiers keep
        // arriving, so the block fills up and has to refuse input.
        rx_hold = HOLD_CYCLES;
        repeat (4) begin
            add_bytes(random_value());
            close_id();
            send_queue();
        end
        wait_drained();
        run_random(20);
        wait_drained();

        tx_idle_pct  = 69;
        rx_stall_pct = 0;
        run_random(40);
        wait_drained();

        tx_idle_pct  = 0;
        rx_stall_pct = 69;
        run_random(40);
        wait_drained();

        tx_idle_pct  = 30;
        rx_stall_pct = 30;
        run_random(40);
        wait_drained();

        $display("Sent %0d items in %0d identifiers under four idle and stall mixes, with one long",
                 items_sent, ids_sent);
        $display("output hold; checked %0d results (%0d identifiers converted, %0d rejected).",
                 sb.checked, sb.ok_ids, sb.invalid_ids);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
